@@ rtl/core/pzs_pkg.sv @@
// pzs_pkg: shared types, constants and sample conditioning for the pulse zero suppression block
// no dependencies; imported by every module in rtl/core
package pzs_pkg;

  localparam int MaxBins    = 32;
  localparam int SampleBits = 12;
  localparam int BinW       = $clog2(MaxBins);
  localparam int LenW       = $clog2(MaxBins + 1);
  localparam int SigW       = 17;
  localparam int SigLimit   = 65520;
  localparam int CfgW       = 20;
  localparam int CfgAddrW   = 3;
  localparam int SqW        = 32;
  localparam int SumW       = 37;
  localparam int CutW       = 24;
  localparam int CutSqW     = 2 * CutW;
  localparam int RhsW       = CutSqW + LenW;
  localparam int LhsW       = SumW + 8;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 24;
  localparam int OutUserW   = 2;

  typedef enum logic [CfgAddrW-1:0] {
    CfgPedMean  = 3'd0,
    CfgPedRms   = 3'd1,
    CfgSigma    = 3'd2,
    CfgFixedCut = 3'd3,
    CfgCutMode  = 3'd4,
    CfgInvert   = 3'd5,
    CfgMinHit   = 3'd6,
    CfgRecLen   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]     ped_mean;
    logic [15:0]     ped_rms;
    logic [7:0]      sigma_mult;
    logic [19:0]     fixed_cut;
    logic            cut_mode;
    logic            invert;
    logic [LenW-1:0] min_hit;
    logic [LenW-1:0] rec_len;
  } cfg_t;

  typedef enum logic [2:0] {
    SIdle,
    SCut,
    SRead,
    SLoad,
    STail
  } state_e;

  typedef struct packed {
    logic [SigW-1:0] value;
    logic [BinW-1:0] bin;
    logic            kept;
    logic            last_burst;
    logic            last_rec;
  } result_t;

  typedef struct packed {
    logic done;
    logic keep;
  } cut_status_t;

  // (raw << 4) - mean, optional negation, saturate to +-SigLimit
  function automatic logic signed [SigW-1:0] condition_sample(
    input logic [SampleBits-1:0] raw,
    input logic [15:0]           mean,
    input logic                  invert
  );
    logic signed [SigW:0] diff;
    logic signed [SigW:0] lim;
    logic signed [SigW-1:0] res;
    diff = $signed({{(SigW - SampleBits - 3){1'b0}}, raw, 4'b0000})
         - $signed({2'b00, mean});
    if (invert) begin
      diff = -diff;
    end
    lim = (SigW + 1)'(SigLimit);
    if (diff > lim) begin
      res = SigW'(SigLimit);
    end else if (diff < -lim) begin
      res = -SigW'(SigLimit);
    end else begin
      res = diff[SigW-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/pzs_run_mem.sv @@
// pzs_run_mem: one-write one-read synchronous store for the samples of the open run
// depends on pzs_pkg for depth and width
module pzs_run_mem import pzs_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [BinW-1:0] waddr_i,
  input  logic [SigW-1:0] wdata_i,
  input  logic [BinW-1:0] raddr_i,
  output logic [SigW-1:0] rdata_o
);

  logic [SigW-1:0] mem [MaxBins];
  logic [SigW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/pzs_cut_unit.sv @@
// pzs_cut_unit: four-stage pipeline that decides whether a closed run is kept
// depends on pzs_pkg for cfg_t, cut_status_t and widths
module pzs_cut_unit import pzs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cfg_t            cfg_i,
  input  logic [LenW-1:0] run_length_i,
  input  logic [SumW-1:0] square_sum_i,
  output cut_status_t     status_o
);

  logic [3:0]        vld_q;
  logic [CutW-1:0]   cut_q;
  logic [CutSqW-1:0] cut_sq_q;
  logic [RhsW-1:0]   rhs_q;
  logic              keep_q;
  logic [CutW-1:0]   cut_d;
  logic [LhsW-1:0]   lhs;
  logic              keep_d;

  always_comb begin
    if (cfg_i.cut_mode) begin
      cut_d = {cfg_i.fixed_cut, 4'b0000};
    end else begin
      cut_d = CutW'(cfg_i.sigma_mult * cfg_i.ped_rms);
    end
  end

  // square sum in q37.8 against run length times cut squared
  assign lhs    = {square_sum_i, 8'h00};
  assign keep_d = ({{(RhsW - LhsW){1'b0}}, lhs} > rhs_q) && (run_length_i > cfg_i.min_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    cut_q    <= cut_d;
    cut_sq_q <= CutSqW'(cut_q * cut_q);
    rhs_q    <= RhsW'(cut_sq_q * run_length_i);
    if (vld_q[2]) begin
      keep_q <= keep_d;
    end
  end

  assign status_o.done = vld_q[3];
  assign status_o.keep = keep_q;

endmodule

@@ rtl/core/pulse_zero_suppression.sv @@
// pulse_zero_suppression: pedestal subtraction and run-based zero suppression of one channel
// depends on pzs_pkg, pzs_run_mem and pzs_cut_unit
//
//   channel   dir   payload                                    accept
//   s_axis    in    tdata[11:0] raw_sample                     tvalid & tready
//   m_axis    out   tdata value/bin, tuser kept/burst, tlast   tvalid & tready
//   cfg       in    cfg_addr_i register index, cfg_wdata_i     cfg_we_i
//
// an item that starts or extends a run yields nothing; an item
// with no open run yields its zero result through the output register.
// closing a run passes through the cut pipeline, then each run item takes a memory read
// and an output load, then the closing zero item when a non-positive sample closed it.
// input is held off while a run drains; reset needs no clearing pass.
module pulse_zero_suppression import pzs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [11:0] raw_sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [16:0] signal_value, [21:17] time_bin
  output logic [OutUserW-1:0] m_axis_tuser,   // [0] kept, [1] last_of_burst
  output logic                m_axis_tlast    // last_of_record
);

  cfg_t            cfg_q;
  state_e          state_q, state_d;
  logic [LenW-1:0] run_length_q, run_length_d;
  logic [BinW-1:0] run_start_q, run_start_d;
  logic [BinW-1:0] bin_q, bin_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic            tail_q, tail_d;
  logic [BinW-1:0] tail_bin_q, tail_bin_d;
  logic            close_last_q, close_last_d;
  logic            keep_q, keep_d;
  logic [SumW-1:0] square_sum_q, square_sum_d;
  logic [SqW-1:0]  pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q;
  result_t         res;

  logic            accept, slot_free, load, clear_sum, cut_start;
  logic            pos, last, run_open, final_item;
  logic signed [SigW-1:0] sig;
  logic [LenW-1:0] len_eff;
  logic            mem_we;
  logic [BinW-1:0] mem_waddr;
  logic [SigW-1:0] mem_rdata;
  cut_status_t     cut_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ped_mean   <= '0;
      cfg_q.ped_rms    <= '0;
      cfg_q.sigma_mult <= 8'd48;
      cfg_q.fixed_cut  <= '0;
      cfg_q.cut_mode   <= 1'b0;
      cfg_q.invert     <= 1'b0;
      cfg_q.min_hit    <= '0;
      cfg_q.rec_len    <= LenW'(MaxBins);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgPedMean:  cfg_q.ped_mean   <= cfg_wdata_i[15:0];
        CfgPedRms:   cfg_q.ped_rms    <= cfg_wdata_i[15:0];
        CfgSigma:    cfg_q.sigma_mult <= cfg_wdata_i[7:0];
        CfgFixedCut: cfg_q.fixed_cut  <= cfg_wdata_i[19:0];
        CfgCutMode:  cfg_q.cut_mode   <= cfg_wdata_i[0];
        CfgInvert:   cfg_q.invert     <= cfg_wdata_i[0];
        CfgMinHit:   cfg_q.min_hit    <= cfg_wdata_i[LenW-1:0];
        CfgRecLen:   cfg_q.rec_len    <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign sig      = condition_sample(s_axis_tdata[SampleBits-1:0], cfg_q.ped_mean,
                                     cfg_q.invert);
  assign pos      = !sig[SigW-1] && (sig != '0);
  assign run_open = (run_length_q != '0);

  always_comb begin
    if (cfg_q.rec_len == '0) begin
      len_eff = LenW'(1);
    end else if (cfg_q.rec_len > LenW'(MaxBins)) begin
      len_eff = LenW'(MaxBins);
    end else begin
      len_eff = cfg_q.rec_len;
    end
  end

  assign last          = ({1'b0, bin_q} + LenW'(1)) >= len_eff;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign final_item    = ((idx_q + LenW'(1)) == run_length_q);

  always_comb begin
    state_d      = state_q;
    run_length_d = run_length_q;
    run_start_d  = run_start_q;
    bin_d        = bin_q;
    idx_d        = idx_q;
    tail_d       = tail_q;
    tail_bin_d   = tail_bin_q;
    close_last_d = close_last_q;
    keep_d       = keep_q;
    pend_d       = '0;
    clear_sum    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = run_length_q[BinW-1:0];
    cut_start    = 1'b0;
    load         = 1'b0;
    res          = '0;

    case (state_q)
      SIdle: begin
        if (accept) begin
          bin_d = last ? '0 : bin_q + BinW'(1);
          if (run_open) begin
            idx_d = '0;
            if (pos) begin
              if (run_length_q < LenW'(MaxBins)) begin
                mem_we       = 1'b1;
                run_length_d = run_length_q + LenW'(1);
                pend_d       = SqW'(sig[15:0] * sig[15:0]);
              end
              if (last) begin
                cut_start    = 1'b1;
                tail_d       = 1'b0;
                close_last_d = 1'b1;
                state_d      = SCut;
              end
            end else begin
              // closing sample follows the run as a zero item
              cut_start    = 1'b1;
              tail_d       = 1'b1;
              tail_bin_d   = bin_q;
              close_last_d = last;
              state_d      = SCut;
            end
          end else if (pos && !last) begin
            mem_we       = 1'b1;
            run_start_d  = bin_q;
            run_length_d = LenW'(1);
            clear_sum    = 1'b1;
            pend_d       = SqW'(sig[15:0] * sig[15:0]);
          end else begin
            load           = 1'b1;
            res.bin        = bin_q;
            res.last_burst = 1'b1;
            res.last_rec   = last;
          end
        end
      end
      SCut: begin
        if (cut_status.done) begin
          keep_d  = cut_status.keep;
          state_d = SRead;
        end
      end
      SRead: begin
        if (slot_free) begin
          state_d = SLoad;
        end
      end
      SLoad: begin
        load           = 1'b1;
        res.value      = keep_q ? mem_rdata : '0;
        res.bin        = run_start_q + idx_q[BinW-1:0];
        res.kept       = keep_q;
        res.last_burst = final_item && !tail_q;
        res.last_rec   = final_item && !tail_q && close_last_q;
        if (final_item) begin
          run_length_d = '0;
          clear_sum    = 1'b1;
          state_d      = tail_q ? STail : SIdle;
        end else begin
          idx_d   = idx_q + LenW'(1);
          state_d = SRead;
        end
      end
      STail: begin
        if (slot_free) begin
          load           = 1'b1;
          res.bin        = tail_bin_q;
          res.last_burst = 1'b1;
          res.last_rec   = close_last_q;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // squares are registered in pend_q, then added into the sum, before the cut pipeline reads it
  assign square_sum_d = (clear_sum ? '0 : square_sum_q) + SumW'(pend_q);
  assign out_valid_d  = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      run_length_q <= '0;
      run_start_q  <= '0;
      bin_q        <= '0;
      idx_q        <= '0;
      tail_q       <= 1'b0;
      tail_bin_q   <= '0;
      close_last_q <= 1'b0;
      keep_q       <= 1'b0;
      square_sum_q <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      run_length_q <= run_length_d;
      run_start_q  <= run_start_d;
      bin_q        <= bin_d;
      idx_q        <= idx_d;
      tail_q       <= tail_d;
      tail_bin_q   <= tail_bin_d;
      close_last_q <= close_last_d;
      keep_q       <= keep_d;
      square_sum_q <= square_sum_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  pzs_run_mem u_run_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (sig),
    .raddr_i (idx_q[BinW-1:0]),
    .rdata_o (mem_rdata)
  );

  pzs_cut_unit u_cut_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cut_start),
    .cfg_i        (cfg_q),
    .run_length_i (run_length_q),
    .square_sum_i (square_sum_q),
    .status_o     (cut_status)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - SigW - BinW){1'b0}}, out_q.bin, out_q.value};
  assign m_axis_tuser  = {out_q.last_burst, out_q.kept};
  assign m_axis_tlast  = out_q.last_rec;

endmodule

@@ sim/tb.sv @@
// tb: self-checking testbench for pulse_zero_suppression (pedestal subtraction, run cut)
// needs pzs_pkg and the rtl/core sources; drives both stream ports and the config port,
// predicts every result item in place and checks them in order
`timescale 1ns / 100ps

module tb;
  import pzs_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int RxHoldCycles = 200;

  typedef struct packed {
    logic [11:0]     raw;
    logic            typed;
    logic [SigW-1:0] value;
    logic [BinW-1:0] bin;
    logic            kept;
    logic            burst;
    logic            rec;
  } stim_row_t;

  // directed part, record length 6, cut zero: any positive run is kept
  localparam stim_row_t DirRows [19] = '{
    '{12'd0,    1'b1, 17'd0, 5'd0, 1'b0, 1'b1, 1'b0},
    '{12'd4095, 1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd1,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd0,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd0,    1'b1, 17'd0, 5'd4, 1'b0, 1'b1, 1'b0},
    '{12'd4095, 1'b1, 17'd0, 5'd5, 1'b0, 1'b1, 1'b1},
    '{12'd7,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd8,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd4095, 1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd1,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd2,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd9,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd4095, 1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd0,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd2048, 1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd4095, 1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd1,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd0,    1'b0, 17'd0, 5'd0, 1'b0, 1'b0, 1'b0},
    '{12'd0,    1'b1, 17'd0, 5'd0, 1'b0, 1'b1, 1'b0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [11:0] raw_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [16:0] signal_value, [21:17] time_bin
  logic [OutUserW-1:0] m_axis_tuser;        // [0] kept, [1] last_of_burst
  logic                m_axis_tlast;

  pulse_zero_suppression dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // register copies
  logic [15:0] ped_mean = '0;
  logic [15:0] ped_rms = '0;
  logic [7:0]  sigma_mult = 8'd48;
  logic [19:0] fixed_cut = '0;
  logic        use_fixed_cut = 1'b0;
  logic        invert = 1'b0;
  logic [5:0]  min_hit = '0;
  logic [5:0]  rec_len = 6'd32;

  // run state of the channel
  int              run_vals [MaxBins];
  int              run_len = 0;
  longint unsigned run_sq = 0;
  int              cur_bin = 0;
  int              run_first_bin = 0;

  result_t step_results[$];
  result_t due_results[$];

  int errors = 0;
  int sent_count = 0;
  int tx_idle_pct = 30;
  int rx_idle_pct = 50;
  logic hold_rx = 1'b0;

  // stimulus shaping
  int ped_raw = 0;
  int pulse_sign = 1;
  int pulse_left = 0;
  int pulse_amp = 1;

  function automatic void emit_bin(input int v, input int bin, input bit kept);
    result_t r;
    r.value = v[SigW-1:0];
    r.bin = bin[BinW-1:0];
    r.kept = kept;
    r.last_burst = 1'b0;
    r.last_rec = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void close_pulse_run();
    longint unsigned cut, lhs, rhs;
    bit keep;
    if (use_fixed_cut) begin
      cut = longint'(fixed_cut);
      cut = cut << 4;
    end else begin
      cut = longint'(sigma_mult);
      cut = cut * longint'(ped_rms);
    end
    lhs = run_sq << 8;
    rhs = cut * cut;
    rhs = rhs * longint'(run_len);
    keep = (lhs > rhs) && (run_len > int'(min_hit));
    for (int i = 0; i < run_len; i++) begin
      emit_bin(keep ? run_vals[i] : 0, run_first_bin + i, keep);
    end
    run_len = 0;
    run_sq = 0;
  endfunction

  // one raw sample in, its result items into step_results
  function automatic void suppress_step(input logic [11:0] raw);
    int s, len;
    bit last;
    step_results.delete();
    s = int'({raw, 4'b0000}) - int'(ped_mean);
    if (invert) s = -s;
    if (s > SigLimit) s = SigLimit;
    if (s < -SigLimit) s = -SigLimit;
    len = int'(rec_len);
    if (len == 0) len = 1;
    if (len > MaxBins) len = MaxBins;
    last = (cur_bin + 1 >= len);
    if (run_len > 0) begin
      if (s > 0) begin
        if (run_len < MaxBins) begin
          run_vals[run_len] = s;
          run_len++;
          run_sq += longint'(s) * longint'(s);
        end
        if (last) close_pulse_run();
      end else begin
        close_pulse_run();
        emit_bin(0, cur_bin, 1'b0);
      end
    end else if (s > 0 && !last) begin
      run_first_bin = cur_bin;
      run_vals[0] = s;
      run_len = 1;
      run_sq = longint'(s) * longint'(s);
    end else begin
      emit_bin(0, cur_bin, 1'b0);
    end
    if (step_results.size() > 0) begin
      step_results[$].last_burst = 1'b1;
      if (last) step_results[$].last_rec = 1'b1;
    end
    if (last) begin
      cur_bin = 0;
      run_len = 0;
      run_sq = 0;
    end else begin
      cur_bin++;
    end
  endfunction

  // mostly pedestal noise and pulses, some fully random samples
  function automatic logic [11:0] next_raw();
    int r, v;
    if (pulse_left > 0) begin
      pulse_left--;
      v = ped_raw + pulse_sign * int'($urandom_range(pulse_amp, 1));
    end else begin
      r = int'($urandom_range(99));
      if (r < 10) begin
        v = int'($urandom_range(4095));
      end else if (r < 40) begin
        pulse_left = int'($urandom_range(8, 1)) - 1;
        pulse_amp = int'($urandom_range(400, 2));
        v = ped_raw + pulse_sign * int'($urandom_range(pulse_amp, 1));
      end else begin
        v = ped_raw + int'($urandom_range(6)) - 3;
      end
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgPedMean:  ped_mean = val[15:0];
      CfgPedRms:   ped_rms = val[15:0];
      CfgSigma:    sigma_mult = val[7:0];
      CfgFixedCut: fixed_cut = val[19:0];
      CfgCutMode:  use_fixed_cut = val[0];
      CfgInvert:   invert = val[0];
      CfgMinHit:   min_hit = val[5:0];
      CfgRecLen:   rec_len = val[5:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input int mean, input int rms, input int sigma, input int fcut,
                           input int mode, input int inv, input int mhit, input int rlen);
    write_reg(CfgPedMean, CfgW'(mean));
    write_reg(CfgPedRms, CfgW'(rms));
    write_reg(CfgSigma, CfgW'(sigma));
    write_reg(CfgFixedCut, CfgW'(fcut));
    write_reg(CfgCutMode, CfgW'(mode));
    write_reg(CfgInvert, CfgW'(inv));
    write_reg(CfgMinHit, CfgW'(mhit));
    write_reg(CfgRecLen, CfgW'(rlen));
    cfg_we_i <= 1'b0;
    ped_raw = mean >> 4;
    pulse_sign = inv ? -1 : 1;
    pulse_left = 0;
  endtask

  task automatic send_sample(input logic [11:0] raw, input bit typed, input result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    suppress_step(raw);
    if (typed) begin
      due_results.insert(due_results.size(), want);
    end else begin
      foreach (step_results[i]) due_results.insert(due_results.size(), step_results[i]);
    end
    sent_count++;
    if (sent_count == 60) hold_rx <= 1'b1;
    if (sent_count == 120) begin
      tx_idle_pct = 50;
      rx_idle_pct <= 30;
    end
    if (sent_count == 240) begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
    end
  endtask

  // finish any open run, then hold the input until every result item is out
  task automatic drain_block();
    while (run_len != 0) send_sample(next_raw(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic random_phase(input int count);
    repeat (count) send_sample(next_raw(), 1'b0, '0);
    drain_block();
  endtask

  // output side: random stalls plus one long hold-off
  int  hold_left = 0;
  bit  hold_used = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_rx && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= RxHoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result item: value %0d bin %0d", $signed(m_axis_tdata[16:0]),
               m_axis_tdata[21:17]);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[16:0] !== want.value) begin
          $error("signal_value: expected %0d, got %0d", $signed(want.value),
                 $signed(m_axis_tdata[16:0]));
          errors++;
        end
        if (m_axis_tdata[21:17] !== want.bin) begin
          $error("time_bin: expected %0d, got %0d", want.bin, m_axis_tdata[21:17]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.kept) begin
          $error("kept: expected %0d, got %0d", want.kept, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.last_burst) begin
          $error("last_of_burst: expected %0d, got %0d", want.last_burst, m_axis_tuser[1]);
          errors++;
        end
        if (m_axis_tlast !== want.last_rec) begin
          $error("last_of_record: expected %0d, got %0d", want.last_rec, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("pulse_zero_suppression test failed");
      $finish;
    end
  end

  initial begin
    result_t want;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CfgRecLen, CfgW'(6));
    cfg_we_i <= 1'b0;
    foreach (DirRows[i]) begin
      want.value = DirRows[i].value;
      want.bin = DirRows[i].bin;
      want.kept = DirRows[i].kept;
      want.last_burst = DirRows[i].burst;
      want.last_rec = DirRows[i].rec;
      send_sample(DirRows[i].raw, DirRows[i].typed, want);
    end
    drain_block();

    // sigma cut around a low pedestal
    load_regs(1600, 32, 48, 0, 0, 0, 1, 32);
    random_phase(100);
    // every sample is positive, length 0 acts as one bin, huge fixed cut
    load_regs(65535, 0, 255, 1048575, 1, 1, 63, 0);
    random_phase(20);
    // largest sigma cut, length past the maximum
    load_regs(32768, 65535, 255, 5, 0, 0, 0, 63);
    random_phase(40);
    // inverted pulses against a fixed cut
    load_regs(1600, 0, 0, 160, 1, 1, 3, 12);
    random_phase(90);
    // zero pedestal, short records
    load_regs(0, 100, 16, 0, 0, 0, 0, 5);
    random_phase(70);

    if (errors == 0) begin
      $display("pulse_zero_suppression test passed");
    end else begin
      $display("pulse_zero_suppression test failed");
    end
    $finish;
  end

endmodule
